FILE: sv/dtd_pkg.sv
// ----------------------------------------------------------------------------
// dtd_pkg
// Shared types and constants for the double-tap detector.
// ----------------------------------------------------------------------------
package dtd_pkg;

  // Field widths
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned TIME_BITS   = 16;
  localparam int unsigned CFG_BITS    = 16;
  localparam int unsigned CFG_IDX_W   = 8;

  // Jump magnitude is one bit wider than a sample so it never wraps
  localparam int unsigned MAG_BITS  = SAMPLE_BITS + 1;
  localparam int unsigned THR_CMP_W = (MAG_BITS > CFG_BITS) ? MAG_BITS : CFG_BITS;
  localparam int unsigned TIM_CMP_W = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

  // Item command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELTA_THRESHOLD = 8'd0,
    CFG_MIN_SPACING     = 8'd1,
    CFG_DOUBLE_WINDOW   = 8'd2,
    CFG_LED_HOLD        = 8'd3
  } cfg_idx_e;

  // Reset values of the configuration registers
  localparam logic [CFG_BITS-1:0] RST_DELTA_THRESHOLD = 16'd13107;
  localparam logic [CFG_BITS-1:0] RST_MIN_SPACING     = 16'd50;
  localparam logic [CFG_BITS-1:0] RST_DOUBLE_WINDOW   = 16'd500;
  localparam logic [CFG_BITS-1:0] RST_LED_HOLD        = 16'd2000;

  typedef struct packed {
    logic [CFG_BITS-1:0] delta_threshold;
    logic [CFG_BITS-1:0] min_spacing;
    logic [CFG_BITS-1:0] double_window;
    logic [CFG_BITS-1:0] led_hold;
  } dtd_cfg_t;

  typedef struct packed {
    logic double_tap;
    logic indicator_on;
  } dtd_result_t;

endpackage

FILE: sv/double_tap_detector.sv
// ----------------------------------------------------------------------------
// double_tap_detector
// Double-tap detection on raw Z acceleration samples and time ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per accepted
//   beat: command_i = 0 for a new sample in sample_i, 1 for a time tick.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result
//   item per input item, in order: double_tap_o and indicator_on_o.
//   Configuration writes use cfg_valid_i / cfg_ready_o with cfg_index_i
//   selecting the register; ready is always high and unknown indexes are
//   ignored. Write only while the block holds no item in flight.
// Pipeline and throughput:
//   An item is captured in the input register, evaluated by the tap core
//   and written to the result register. One item per cycle is sustained
//   while the output is not stalled, set by the single state-update pass
//   through the tap core.
// Reset: control and detector state clear, registers return to defaults.
// Stall: a held result blocks the input register only once both are full;
//   in_stall_o then rises until the result is taken.
// ----------------------------------------------------------------------------
module double_tap_detector (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   command_i,
  input  logic signed [dtd_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   double_tap_o,
  output logic                                   indicator_on_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [dtd_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [dtd_pkg::CFG_BITS-1:0]           cfg_data_i
);
  import dtd_pkg::*;

  dtd_cfg_t                      cfg;
  dtd_result_t                   result;
  logic                          in_vld_q;
  logic                          cmd_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          out_vld_q;
  dtd_result_t                   res_q;
  logic                          advance, step, in_take;

  // Result register free or emptied this cycle
  assign advance    = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  dtd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dtd_tap_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .command_i (cmd_q),
    .sample_i  (sample_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q    <= command_i;
      sample_q <= sample_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= result;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign double_tap_o   = res_q.double_tap;
  assign indicator_on_o = res_q.indicator_on;

  // Assertions
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q)
    else $error("input item dropped while result stalled");
  a_step_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("evaluated item produced no result");
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_vld_q && out_stall_i)
    else $error("input stalled with free result register");

endmodule

FILE: sv/dtd_cfg_regs.sv
// ----------------------------------------------------------------------------
// dtd_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module dtd_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dtd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dtd_pkg::CFG_BITS-1:0]  cfg_data_i,
  output dtd_pkg::dtd_cfg_t           cfg_o
);
  import dtd_pkg::*;

  dtd_cfg_t cfg_q, cfg_d;
  logic     wr_en;

  // Always able to take a write
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  // Address decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DELTA_THRESHOLD: cfg_d.delta_threshold = cfg_data_i;
        CFG_MIN_SPACING:     cfg_d.min_spacing     = cfg_data_i;
        CFG_DOUBLE_WINDOW:   cfg_d.double_window   = cfg_data_i;
        CFG_LED_HOLD:        cfg_d.led_hold        = cfg_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delta_threshold <= RST_DELTA_THRESHOLD;
      cfg_q.min_spacing     <= RST_MIN_SPACING;
      cfg_q.double_window   <= RST_DOUBLE_WINDOW;
      cfg_q.led_hold        <= RST_LED_HOLD;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

  // Assertions
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_valid_i |=> cfg_q == $past(cfg_q))
    else $error("config changed without a write");
  a_led_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_index_i == CFG_LED_HOLD |=> cfg_q.led_hold == $past(cfg_data_i))
    else $error("led_hold write lost");
  a_bad_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_index_i != CFG_DELTA_THRESHOLD && cfg_index_i != CFG_MIN_SPACING &&
    cfg_index_i != CFG_DOUBLE_WINDOW && cfg_index_i != CFG_LED_HOLD
    |=> cfg_q == $past(cfg_q))
    else $error("out-of-range write changed config");

endmodule

FILE: sv/dtd_tap_core.sv
// ----------------------------------------------------------------------------
// dtd_tap_core
// Detector state and the per-item compare-and-update logic.
// ----------------------------------------------------------------------------
module dtd_tap_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          command_i,
  input  logic signed [dtd_pkg::SAMPLE_BITS-1:0] sample_i,
  input  dtd_pkg::dtd_cfg_t             cfg_i,
  output dtd_pkg::dtd_result_t          result_o
);
  import dtd_pkg::*;

  logic signed [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic [TIME_BITS-1:0]          ticks_q, ticks_d;
  logic [CFG_BITS-1:0]           hold_q, hold_d;

  logic signed [MAG_BITS-1:0]    diff;
  logic [MAG_BITS-1:0]           mag;
  logic [THR_CMP_W-1:0]          mag_x, thr_x;
  logic [TIM_CMP_W-1:0]          ticks_x, spacing_x, window_x;
  logic                          is_tick, tap_counted, dbl;

  // Jump magnitude, exact at one bit wider than a sample
  assign diff = MAG_BITS'(sample_i) - MAG_BITS'(prev_q);
  assign mag  = diff[MAG_BITS-1] ? (~diff + MAG_BITS'(1)) : diff;

  assign mag_x     = THR_CMP_W'(mag);
  assign thr_x     = THR_CMP_W'(cfg_i.delta_threshold);
  assign ticks_x   = TIM_CMP_W'(ticks_q);
  assign spacing_x = TIM_CMP_W'(cfg_i.min_spacing);
  assign window_x  = TIM_CMP_W'(cfg_i.double_window);

  assign is_tick     = (command_i == CMD_TICK);
  assign tap_counted = !is_tick && (mag_x > thr_x) && (ticks_x > spacing_x);
  assign dbl         = tap_counted && (ticks_x < window_x);

  // Next state
  always_comb begin
    prev_d  = prev_q;
    ticks_d = ticks_q;
    hold_d  = hold_q;
    if (is_tick) begin
      if (hold_q != '0) hold_d = hold_q - CFG_BITS'(1);
      if (ticks_q != '1) ticks_d = ticks_q + TIME_BITS'(1);
    end else begin
      prev_d = sample_i;
      if (tap_counted) ticks_d = '0;
      if (dbl)         hold_d  = cfg_i.led_hold;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      ticks_q <= '0;
      hold_q  <= '0;
    end else if (step_i) begin
      prev_q  <= prev_d;
      ticks_q <= ticks_d;
      hold_q  <= hold_d;
    end
  end

  // Result reflects the state after this item
  assign result_o.double_tap   = dbl;
  assign result_o.indicator_on = (hold_d != '0);

  // Assertions
  a_tick_no_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && is_tick |-> !result_o.double_tap)
    else $error("double tap on a tick item");
  a_hold_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && dbl |=> hold_q == $past(cfg_i.led_hold))
    else $error("hold counter not loaded on double tap");
  a_tap_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && tap_counted |=> ticks_q == '0)
    else $error("elapsed ticks not cleared on counted tap");
  a_ticks_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && is_tick && ticks_q == '1 |=> ticks_q == '1)
    else $error("elapsed ticks wrapped");

endmodule
